// ===== rtl/dvrt_pkg.sv =====
// ----------------------------------------------------------------------------
// dvrt_pkg
// Shared types and constants of the distance-vector route table.
// ----------------------------------------------------------------------------
package dvrt_pkg;

	localparam int unsigned NODES_DEF     = 8;
	localparam int unsigned COST_BITS_DEF = 16;
	localparam int unsigned SLOT_W        = 3;
	localparam int unsigned CNT_W         = 4;
	localparam int unsigned MODE_W        = 3;
	localparam int unsigned STAT_W        = 3;
	localparam int unsigned OUT_COST_W    = 16;

	typedef enum logic [MODE_W-1:0] {
		MODE_ADVERT  = 3'd0,
		MODE_LOAD    = 3'd1,
		MODE_UPDATE  = 3'd2,
		MODE_DISABLE = 3'd3,
		MODE_CRASH   = 3'd4,
		MODE_READ    = 3'd5
	} mode_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 3'd0,
		ST_BAD_HOST = 3'd1,
		ST_BAD_IDX  = 3'd2,
		ST_NOT_NBR  = 3'd3,
		ST_DISABLED = 3'd4,
		ST_CRASHED  = 3'd5
	} status_t;

	localparam logic REG_HOST  = 1'b0;
	localparam logic REG_COUNT = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic exec;
		logic pass_init;
		logic pass_link;
		logic pass_relax;
		logic finish;
	} dvrt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic apply;
		logic pass_last;
	} dvrt_stat_t;

endpackage

// ===== rtl/dvrt_ctrl.sv =====
// ----------------------------------------------------------------------------
// dvrt_ctrl
// Sequencer: one exec step; an applying last advert word adds two passes.
// ----------------------------------------------------------------------------
module dvrt_ctrl
	import dvrt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  dvrt_stat_t stat,
	output dvrt_cmd_t  cmd,
	output logic       busy
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_EXEC  = 5'b00010,
		S_LINK  = 5'b00100,
		S_RELAX = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				if (stat.apply) begin
					cmd.pass_init = 1'b1;
					state_d       = S_LINK;
				end else begin
					state_d = S_DONE;
				end
			end
			S_LINK: begin
				cmd.pass_link = 1'b1;
				if (stat.pass_last) begin
					cmd.pass_init = 1'b1;
					state_d       = S_RELAX;
				end
			end
			S_RELAX: begin
				cmd.pass_relax = 1'b1;
				if (stat.pass_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ===== rtl/dvrt_dpath.sv =====
// ----------------------------------------------------------------------------
// dvrt_dpath
// Route table, advert buffer and one relaxation step per cycle.
// ----------------------------------------------------------------------------
module dvrt_dpath
	import dvrt_pkg::*;
#(
	parameter int unsigned NODES     = NODES_DEF,
	parameter int unsigned COST_BITS = COST_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dvrt_cmd_t             cmd,
	output dvrt_stat_t            stat,
	input  logic                  cfg_we,
	input  logic                  cfg_idx,
	input  logic [CNT_W-1:0]      cfg_data,
	input  logic [MODE_W-1:0]     mode,
	input  logic [SLOT_W-1:0]     sender_slot,
	input  logic [SLOT_W-1:0]     dest_slot,
	input  logic [OUT_COST_W-1:0] cost_value,
	input  logic                  last_entry,
	output logic                  done,
	output logic [STAT_W-1:0]     status,
	output logic [OUT_COST_W-1:0] route_cost,
	output logic [SLOT_W-1:0]     next_hop,
	output logic                  hop_valid
);

	localparam int unsigned IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int unsigned FIL_W = $clog2(NODES + 1);
	localparam logic [COST_BITS-1:0] INF = '1;

	logic [COST_BITS-1:0] rc_q [NODES];
	logic [SLOT_W-1:0]    nh_q [NODES];
	logic [NODES-1:0]     hv_q, nb_q, dis_q;
	logic [COST_BITS-1:0] lc_q [NODES];
	logic                 crash_q;
	logic [SLOT_W-1:0]    ad_q [NODES];
	logic [COST_BITS-1:0] ac_q [NODES];
	logic [FIL_W-1:0]     fill_q, k_q;
	logic [SLOT_W-1:0]    host_q;
	logic [CNT_W-1:0]     count_q;

	logic [MODE_W-1:0]     mode_q;
	logic [SLOT_W-1:0]     snd_q, dst_q;
	logic [COST_BITS-1:0]  cost_q;
	logic                  last_q;
	logic [STAT_W-1:0]     st_q;

	function automatic logic slot_ok(input logic [CNT_W-1:0] cnt, input logic [SLOT_W-1:0] s);
		logic [CNT_W:0] lim;
		lim = (32'(cnt) > NODES) ? (CNT_W+1)'(NODES) : {1'b0, cnt};
		return ({{(CNT_W+1-SLOT_W){1'b0}}, s} < lim) && (32'(s) < NODES);
	endfunction

	logic                 snd_ok, dst_ok;
	logic [IDX_W-1:0]     di, si, kd;
	logic [COST_BITS:0]   sum;
	logic [COST_BITS-1:0] effc;
	logic [SLOT_W-1:0]    kdst;
	logic [COST_BITS-1:0] kcost;
	logic                 kskip;

	assign snd_ok = slot_ok(count_q, snd_q);
	assign dst_ok = slot_ok(count_q, dst_q);
	assign di     = IDX_W'(dst_q);
	assign si     = IDX_W'(snd_q);

	assign kdst  = ad_q[IDX_W'(k_q)];
	assign kcost = ac_q[IDX_W'(k_q)];
	assign kd    = IDX_W'(kdst);
	assign kskip = (kdst == host_q) && !dis_q[si];
	assign sum   = {1'b0, kcost} + {1'b0, lc_q[si]};
	assign effc  = (kdst == host_q && !nb_q[kd] && !crash_q) ? '0 : rc_q[kd];

	// A last advert word, valid sender, no crash and a non-empty buffer: apply.
	assign stat.apply     = (mode_q == MODE_ADVERT) && !crash_q && last_q && snd_ok &&
		((dst_ok && 32'(fill_q) < NODES) || fill_q != '0);
	assign stat.pass_last = ({1'b0, k_q} + 1'b1) >= {1'b0, fill_q};

	logic [COST_BITS-1:0] in_cost;
	always_comb begin
		if (COST_BITS >= OUT_COST_W) begin
			in_cost = COST_BITS'(cost_value);
		end else begin
			in_cost = (cost_value >= OUT_COST_W'(INF)) ? INF : COST_BITS'(cost_value);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode;
			snd_q  <= sender_slot;
			dst_q  <= dest_slot;
			cost_q <= in_cost;
			last_q <= last_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NODES; i++) begin
				rc_q[i] <= INF;
				lc_q[i] <= INF;
				nh_q[i] <= '0;
			end
			hv_q    <= '0;
			nb_q    <= '0;
			dis_q   <= '0;
			crash_q <= 1'b0;
			fill_q  <= '0;
			k_q     <= '0;
			host_q  <= '0;
			count_q <= CNT_W'(5);
			st_q    <= ST_OK;
			done    <= 1'b0;
		end else begin
			done <= cmd.finish;
			if (cfg_we) begin
				if (cfg_idx == REG_HOST) begin
					host_q <= cfg_data[SLOT_W-1:0];
				end else begin
					count_q <= cfg_data;
				end
			end
			if (cmd.pass_init) begin
				k_q <= '0;
			end else if (cmd.pass_link || cmd.pass_relax) begin
				k_q <= k_q + 1'b1;
			end
			if (cmd.exec) begin
				st_q <= ST_OK;
				case (mode_q)
					MODE_ADVERT: begin
						if (crash_q) begin
							st_q   <= ST_CRASHED;
							fill_q <= '0;
						end else begin
							if (!dst_ok) begin
								st_q <= ST_BAD_IDX;
							end else if (32'(fill_q) < NODES) begin
								ad_q[IDX_W'(fill_q)] <= dst_q;
								ac_q[IDX_W'(fill_q)] <= cost_q;
								fill_q <= fill_q + 1'b1;
							end
							if (last_q && !snd_ok) begin
								st_q   <= ST_BAD_IDX;
								fill_q <= '0;
							end
						end
					end
					MODE_LOAD: begin
						if (crash_q) begin
							st_q <= ST_CRASHED;
						end else if (!dst_ok) begin
							st_q <= ST_BAD_IDX;
						end else begin
							lc_q[di]  <= cost_q;
							rc_q[di]  <= cost_q;
							nh_q[di]  <= dst_q;
							hv_q[di]  <= 1'b1;
							nb_q[di]  <= 1'b1;
						end
					end
					MODE_UPDATE: begin
						if (!snd_ok || snd_q != host_q) begin
							st_q <= ST_BAD_HOST;
						end else if (!dst_ok) begin
							st_q <= ST_BAD_IDX;
						end else if (!nb_q[di]) begin
							st_q <= ST_NOT_NBR;
						end else if (dis_q[di]) begin
							st_q <= ST_DISABLED;
						end else begin
							if ((hv_q[di] && nh_q[di] == dst_q) || cost_q < rc_q[di]) begin
								rc_q[di] <= cost_q;
								nh_q[di] <= dst_q;
								hv_q[di] <= 1'b1;
							end
							lc_q[di] <= cost_q;
						end
					end
					MODE_DISABLE: begin
						if (!dst_ok) begin
							st_q <= ST_BAD_IDX;
						end else if (!nb_q[di]) begin
							st_q <= ST_NOT_NBR;
						end else if (dis_q[di]) begin
							st_q <= ST_DISABLED;
						end else begin
							if (hv_q[di] && nh_q[di] == dst_q) begin
								rc_q[di] <= INF;
								nh_q[di] <= '0;
								hv_q[di] <= 1'b0;
							end
							lc_q[di]  <= INF;
							dis_q[di] <= 1'b1;
						end
					end
					MODE_CRASH: begin
						crash_q <= 1'b1;
						fill_q  <= '0;
						for (int i = 0; i < NODES; i++) begin
							if (slot_ok(count_q, SLOT_W'(i))) begin
								rc_q[i]  <= INF;
								nh_q[i]  <= '0;
								hv_q[i]  <= 1'b0;
								dis_q[i] <= 1'b1;
							end
						end
					end
					MODE_READ: begin
						if (!dst_ok) begin
							st_q <= ST_BAD_IDX;
						end
					end
					default: st_q <= ST_BAD_IDX;
				endcase
			end
			if (cmd.pass_link) begin
				if (kskip) begin
					lc_q[si] <= kcost;
					if (hv_q[si] && nh_q[si] == snd_q) begin
						rc_q[si] <= kcost;
					end
				end
			end
			if (cmd.pass_relax) begin
				if (!kskip && kcost != INF && sum < {1'b0, INF} && sum < {1'b0, effc}) begin
					rc_q[kd] <= sum[COST_BITS-1:0];
					nh_q[kd] <= snd_q;
					hv_q[kd] <= 1'b1;
				end
				if (stat.pass_last) begin
					fill_q <= '0;
				end
			end
		end
	end

	// Result word, formed in the final cycle from the updated table.
	logic [COST_BITS-1:0] rd_cost;
	always_comb begin
		if (!dst_ok) begin
			rd_cost = INF;
		end else if (dst_q == host_q && !nb_q[di] && !crash_q) begin
			rd_cost = '0;
		end else begin
			rd_cost = rc_q[di];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status <= st_q;
			if (!dst_ok) begin
				next_hop  <= '0;
				hop_valid <= 1'b0;
			end else if (dst_q == host_q && !nb_q[di] && !crash_q) begin
				next_hop  <= host_q;
				hop_valid <= 1'b0;
			end else begin
				next_hop  <= nh_q[di];
				hop_valid <= hv_q[di];
			end
			if (COST_BITS >= OUT_COST_W) begin
				route_cost <= rd_cost[OUT_COST_W-1:0];
			end else begin
				route_cost <= OUT_COST_W'(rd_cost);
			end
		end
	end

endmodule

// ===== rtl/distance_vector_route_table_unit.sv =====
// ----------------------------------------------------------------------------
// distance_vector_route_table_unit
// Distance-vector routing table with buffered advertisements.
// ----------------------------------------------------------------------------
// A word runs through the exec and done states; a last advert word that
// has a buffer to apply also runs a link pass and a relax pass, one
// buffered entry per cycle per pass. A new word is accepted only in idle,
// after the previous run; busy covers the whole run.
// Reset clears the table to infinity and all flags at once; the receiver
// cannot stall, each result shows for one cycle with done.
module distance_vector_route_table_unit
	import dvrt_pkg::*;
#(
	parameter int unsigned NODES     = NODES_DEF,
	parameter int unsigned COST_BITS = COST_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	output logic                  done,
	input  logic                  cfg_we,
	input  logic                  cfg_idx,
	input  logic [CNT_W-1:0]      cfg_data,
	input  logic [MODE_W-1:0]     mode,
	input  logic [SLOT_W-1:0]     sender_slot,
	input  logic [SLOT_W-1:0]     dest_slot,
	input  logic [OUT_COST_W-1:0] cost_value,
	input  logic                  last_entry,
	output logic [STAT_W-1:0]     status,
	output logic [OUT_COST_W-1:0] route_cost,
	output logic [SLOT_W-1:0]     next_hop,
	output logic                  hop_valid
);

	dvrt_cmd_t  cmd;
	dvrt_stat_t stat;

	dvrt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	dvrt_dpath #(
		.NODES     (NODES),
		.COST_BITS (COST_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_data    (cfg_data),
		.mode        (mode),
		.sender_slot (sender_slot),
		.dest_slot   (dest_slot),
		.cost_value  (cost_value),
		.last_entry  (last_entry),
		.done        (done),
		.status      (status),
		.route_cost  (route_cost),
		.next_hop    (next_hop),
		.hop_valid   (hop_valid)
	);

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held for two cycles");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted word did not raise busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without a run");

endmodule
